// ===== hw/rtl/ternary_linear_layer_defines.svh =====
// assertion macros for the ternary linear layer
// no dependencies; taken in by every file that carries assertions
`ifndef TERNARY_LINEAR_LAYER_DEFINES_SVH
`define TERNARY_LINEAR_LAYER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked at every edge outside reset
`define TLL_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define TLL_ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLL_ASSERT_RST(label, clk, rst, prop, msg)
`define TLL_ASSERT_ALL(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/tll_pkg.sv =====
// shared types and constants of the ternary linear layer
// no dependencies
package tll_pkg;

   localparam int OP_W       = 2;
   localparam int ROW_W      = 4;
   localparam int COL_W      = 8;
   localparam int WGT_W      = 16;
   localparam int BIAS_W     = 32;
   localparam int ACT_W      = 16;
   localparam int ACC_W      = 32;
   localparam int IDX_W      = 4;
   localparam int CNT_W      = 9;
   localparam int OUTC_W     = 5;
   localparam int CONTRIB_W  = 48;
   localparam int SUM_W      = 49;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // request tdata layout, lowest bit first
   localparam int ROW_LSB  = 0;
   localparam int COL_LSB  = ROW_LSB + ROW_W;
   localparam int WGT_LSB  = COL_LSB + COL_W;
   localparam int BIAS_LSB = WGT_LSB + WGT_W;
   localparam int ACT_LSB  = BIAS_LSB + BIAS_W;

   typedef enum logic [OP_W-1:0] {
      OP_WEIGHT = 2'd0,
      OP_BIAS   = 2'd1,
      OP_ACT    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      REG_IN_COUNT    = 2'd0,
      REG_OUT_COUNT   = 2'd1,
      REG_WEIGHT_MODE = 2'd2
   } reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_WAIT,
      ST_OUT_RD,
      ST_OUT_LD
   } state_type;

   typedef struct packed {
      logic [CNT_W-1:0]  in_eff;
      logic [OUTC_W-1:0] out_eff;
      logic              mode;
   } cfg_type;

   typedef struct packed {
      logic vld;
      logic calc;
      logic first;
   } rd_ctl_type;

endpackage

// ===== hw/rtl/ternary_linear_layer.sv =====
// top level of the ternary linear layer: sequencer, result register, glue
// depends on tll_pkg, tll_csr, tll_store, tll_mac and the assertion header
//
//  channel | direction | role
//  req_*   | in        | weight write, bias write or one activation element
//  rsp_*   | out       | one result per output feature, tlast on the final one
//  csr_*   | in/out    | in_count, out_count, weight_mode at byte 0, 4, 8
//
// an activation: the single multiplier is shared by all outputs, one
// accumulator read-modify-write a cycle, then the pipe drains
// a completed vector gives out_count results, each read, then registered to rsp
// reset needs no clearing pass; rsp_tready low stalls the result sequence only
`include "ternary_linear_layer_defines.svh"
module ternary_linear_layer #(
   parameter int OUT_MAX   = 16,
   parameter int IN_MAX    = 256,
   parameter int ACT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [3:0] row_index, [11:4] col_index, [27:12] weight_value,
   // [59:28] bias_value, [75:60] activation, [79:76] zero
   input  logic [tll_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] operation
   input  logic [tll_pkg::OP_W-1:0]          req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] result
   output logic [tll_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [3:0] out_index
   output logic [tll_pkg::IDX_W-1:0]         rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tll_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [tll_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [tll_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int OW    = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
   localparam int IW    = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
   localparam int DEPTH = OUT_MAX * IN_MAX;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   tll_pkg::cfg_type                 cfg;
   tll_pkg::op_type                  op;
   tll_pkg::state_type               state_ff, state_in;
   tll_pkg::rd_ctl_type              rd_ctl, rd_ctl_q;

   logic [tll_pkg::ROW_W-1:0]        req_row;
   logic [tll_pkg::COL_W-1:0]        req_col;
   logic [tll_pkg::WGT_W-1:0]        req_wgt;
   logic [tll_pkg::BIAS_W-1:0]       req_bias;
   logic [tll_pkg::ACT_W-1:0]        req_act;
   logic                             accept;

   logic [OW-1:0]                    oc_ff, oc_in;
   logic [tll_pkg::CNT_W-1:0]        cnt_ff, cnt_in, cnt_next;
   logic [IW-1:0]                    k_ff, k_in;
   logic [tll_pkg::ACT_W-1:0]        act_ff, act_in;
   logic                             first_ff, first_in;
   logic                             done_ff, done_in;

   logic                             rsp_tvalid_ff, rsp_tvalid_in;
   logic [tll_pkg::IDX_W-1:0]        rsp_idx_ff, rsp_idx_in;
   logic [tll_pkg::ACC_W-1:0]        rsp_data_ff, rsp_data_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             wgt_we, bias_we, acc_we;
   logic [AW-1:0]                    wgt_waddr, rd_waddr;
   logic [OW-1:0]                    rd_idx, rd_idx_q, acc_waddr;
   logic [tll_pkg::WGT_W-1:0]        wgt_rdata;
   logic [tll_pkg::BIAS_W-1:0]       bias_rdata;
   logic [tll_pkg::ACC_W-1:0]        acc_rdata, acc_wdata;
   logic                             mac_busy, busy, rsp_free;

   assign op       = tll_pkg::op_type'(req_tuser);
   assign req_row  = req_tdata[tll_pkg::ROW_LSB  +: tll_pkg::ROW_W];
   assign req_col  = req_tdata[tll_pkg::COL_LSB  +: tll_pkg::COL_W];
   assign req_wgt  = req_tdata[tll_pkg::WGT_LSB  +: tll_pkg::WGT_W];
   assign req_bias = req_tdata[tll_pkg::BIAS_LSB +: tll_pkg::BIAS_W];
   assign req_act  = req_tdata[tll_pkg::ACT_LSB  +: tll_pkg::ACT_W];

   assign req_tready = (state_ff == tll_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // writes are only taken in idle, so no read-modify-write is in flight
   assign wgt_we    = accept && (op == tll_pkg::OP_WEIGHT) &&
                      (32'(req_row) < OUT_MAX) && (32'(req_col) < IN_MAX);
   assign wgt_waddr = AW'(32'(req_col) * OUT_MAX + 32'(req_row));
   assign bias_we   = accept && (op == tll_pkg::OP_BIAS) && (32'(req_row) < OUT_MAX);
   assign rd_waddr  = AW'(32'(k_ff) * OUT_MAX + 32'(oc_ff));
   assign rd_idx    = oc_ff;

   assign busy     = (rd_ctl_q.vld && rd_ctl_q.calc) || mac_busy;
   assign rsp_free = !rsp_tvalid_ff || rsp_tready;
   assign cnt_next = cnt_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      oc_in         = oc_ff;
      cnt_in        = cnt_ff;
      k_in          = k_ff;
      act_in        = act_ff;
      first_in      = first_ff;
      done_in       = done_ff;
      rd_ctl        = '0;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_idx_in    = rsp_idx_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         tll_pkg::ST_IDLE: begin
            if (accept && op == tll_pkg::OP_ACT) begin
               act_in   = req_act;
               first_in = (cnt_ff == '0);
               k_in     = (32'(cnt_ff) >= IN_MAX) ? IW'(IN_MAX - 1) : IW'(cnt_ff);
               done_in  = (cnt_next >= cfg.in_eff);
               cnt_in   = (cnt_next >= cfg.in_eff) ? '0 : cnt_next;
               oc_in    = '0;
               state_in = tll_pkg::ST_CALC;
            end
         end
         tll_pkg::ST_CALC: begin
            rd_ctl.vld   = 1'b1;
            rd_ctl.calc  = 1'b1;
            rd_ctl.first = first_ff;
            if (32'(oc_ff) == OUT_MAX - 1) begin
               oc_in    = '0;
               state_in = tll_pkg::ST_WAIT;
            end else begin
               oc_in = oc_ff + 1'b1;
            end
         end
         tll_pkg::ST_WAIT: begin
            if (!busy)
               state_in = done_ff ? tll_pkg::ST_OUT_RD : tll_pkg::ST_IDLE;
         end
         tll_pkg::ST_OUT_RD: begin
            if (rsp_free) begin
               rd_ctl.vld = 1'b1;
               state_in   = tll_pkg::ST_OUT_LD;
            end
         end
         tll_pkg::ST_OUT_LD: begin
            rsp_tvalid_in = 1'b1;
            rsp_idx_in    = tll_pkg::IDX_W'(32'(oc_ff));
            rsp_data_in   = acc_rdata;
            rsp_last_in   = (32'(oc_ff) + 1 == 32'(cfg.out_eff));
            if (32'(oc_ff) + 1 == 32'(cfg.out_eff)) begin
               oc_in    = '0;
               state_in = tll_pkg::ST_IDLE;
            end else begin
               oc_in    = oc_ff + 1'b1;
               state_in = tll_pkg::ST_OUT_RD;
            end
         end
         default: state_in = tll_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tll_pkg::ST_IDLE;
         oc_ff         <= '0;
         cnt_ff        <= '0;
         first_ff      <= 1'b0;
         done_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         oc_ff         <= oc_in;
         cnt_ff        <= cnt_in;
         first_ff      <= first_in;
         done_ff       <= done_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      k_ff        <= k_in;
      act_ff      <= act_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_idx_ff;
   assign rsp_tlast  = rsp_last_ff;

   tll_csr #(
      .IN_MAX  (IN_MAX),
      .OUT_MAX (OUT_MAX)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tll_store #(
      .IN_MAX  (IN_MAX),
      .OUT_MAX (OUT_MAX)
   ) u_store (
      .clock         (clock),
      .reset         (reset),
      .wgt_we        (wgt_we),
      .wgt_waddr     (wgt_waddr),
      .wgt_wdata     (req_wgt),
      .bias_we       (bias_we),
      .bias_waddr    (OW'(req_row)),
      .bias_wdata    (req_bias),
      .acc_we        (acc_we),
      .acc_waddr     (acc_waddr),
      .acc_wdata     (acc_wdata),
      .rd_ctl        (rd_ctl),
      .rd_waddr      (rd_waddr),
      .rd_idx        (rd_idx),
      .rd_ctl_ff     (rd_ctl_q),
      .rd_idx_ff     (rd_idx_q),
      .wgt_rdata_ff  (wgt_rdata),
      .bias_rdata_ff (bias_rdata),
      .acc_rdata_ff  (acc_rdata)
   );

   tll_mac #(
      .OUT_MAX   (OUT_MAX),
      .ACT_WIDTH (ACT_WIDTH)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .rd_ctl    (rd_ctl_q),
      .rd_idx    (rd_idx_q),
      .wgt       (wgt_rdata),
      .bias      (bias_rdata),
      .acc       (acc_rdata),
      .act       (act_ff),
      .mode      (cfg.mode),
      .acc_we    (acc_we),
      .acc_waddr (acc_waddr),
      .acc_wdata (acc_wdata),
      .busy      (mac_busy)
   );

   `TLL_ASSERT_RST(a_no_accept_while_busy, clock, reset, (req_tvalid && req_tready) |-> !busy, "item accepted while accumulator updates in flight")
   `TLL_ASSERT_RST(a_load_into_empty_slot, clock, reset, (state_ff == tll_pkg::ST_OUT_LD) |-> !rsp_tvalid_ff, "result loaded over an untaken beat")
   `TLL_ASSERT_RST(a_gap_after_last, clock, reset, (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid, "result beat straight after the last of a vector")
   `TLL_ASSERT_RST(a_no_acc_write_in_idle, clock, reset, (state_ff == tll_pkg::ST_IDLE) |-> !acc_we, "accumulator written while idle")
   `TLL_ASSERT_ALL(a_rsp_clear_after_reset, clock, $past(reset) |-> !rsp_tvalid_ff, "result valid straight after reset")

endmodule

// ===== hw/rtl/tll_csr.sv =====
// configuration registers of the ternary linear layer, apb-style port
// depends on tll_pkg
module tll_csr #(
   parameter int IN_MAX  = 256,
   parameter int OUT_MAX = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tll_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tll_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tll_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output tll_pkg::cfg_type                 cfg
);

   logic [tll_pkg::CNT_W-1:0]  in_count_ff, in_count_in;
   logic [tll_pkg::OUTC_W-1:0] out_count_ff, out_count_in;
   logic                       mode_ff, mode_in;
   logic                       wr;
   tll_pkg::reg_type           sel;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign sel = tll_pkg::reg_type'(csr_paddr[3:2]);

   always_comb begin
      in_count_in  = in_count_ff;
      out_count_in = out_count_ff;
      mode_in      = mode_ff;
      csr_prdata   = '0;
      unique case (sel)
         tll_pkg::REG_IN_COUNT: begin
            csr_prdata = tll_pkg::CSR_DATA_W'(in_count_ff);
            if (wr) in_count_in = csr_pwdata[tll_pkg::CNT_W-1:0];
         end
         tll_pkg::REG_OUT_COUNT: begin
            csr_prdata = tll_pkg::CSR_DATA_W'(out_count_ff);
            if (wr) out_count_in = csr_pwdata[tll_pkg::OUTC_W-1:0];
         end
         tll_pkg::REG_WEIGHT_MODE: begin
            csr_prdata = tll_pkg::CSR_DATA_W'(mode_ff);
            if (wr) mode_in = csr_pwdata[0];
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_count_ff  <= tll_pkg::CNT_W'(256);
         out_count_ff <= tll_pkg::OUTC_W'(16);
         mode_ff      <= 1'b0;
      end else begin
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         mode_ff      <= mode_in;
      end
   end

   // zero acts as one, values beyond the build limits are clamped
   always_comb begin
      if (in_count_ff == '0)
         cfg.in_eff = tll_pkg::CNT_W'(1);
      else if (32'(in_count_ff) > IN_MAX)
         cfg.in_eff = tll_pkg::CNT_W'(IN_MAX);
      else
         cfg.in_eff = in_count_ff;
      if (out_count_ff == '0)
         cfg.out_eff = tll_pkg::OUTC_W'(1);
      else if (32'(out_count_ff) > OUT_MAX)
         cfg.out_eff = tll_pkg::OUTC_W'(OUT_MAX);
      else
         cfg.out_eff = out_count_ff;
      cfg.mode = mode_ff;
   end

endmodule

// ===== hw/rtl/tll_store.sv =====
// weight, bias and accumulator storage of the ternary linear layer
// registered reads; depends on tll_pkg
module tll_store #(
   parameter int IN_MAX  = 256,
   parameter int OUT_MAX = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wgt_we,
   input  logic [AW-1:0]                 wgt_waddr,
   input  logic [tll_pkg::WGT_W-1:0]     wgt_wdata,
   input  logic                          bias_we,
   input  logic [OW-1:0]                 bias_waddr,
   input  logic [tll_pkg::BIAS_W-1:0]    bias_wdata,
   input  logic                          acc_we,
   input  logic [OW-1:0]                 acc_waddr,
   input  logic [tll_pkg::ACC_W-1:0]     acc_wdata,
   input  tll_pkg::rd_ctl_type           rd_ctl,
   input  logic [AW-1:0]                 rd_waddr,
   input  logic [OW-1:0]                 rd_idx,
   output tll_pkg::rd_ctl_type           rd_ctl_ff,
   output logic [OW-1:0]                 rd_idx_ff,
   output logic [tll_pkg::WGT_W-1:0]     wgt_rdata_ff,
   output logic [tll_pkg::BIAS_W-1:0]    bias_rdata_ff,
   output logic [tll_pkg::ACC_W-1:0]     acc_rdata_ff
);

   localparam int OW    = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
   localparam int DEPTH = OUT_MAX * IN_MAX;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // weight entry for row r, column c lies at c*OUT_MAX + r: one column is a run
   logic [tll_pkg::WGT_W-1:0]  wgt_mem  [DEPTH];
   logic [tll_pkg::BIAS_W-1:0] bias_mem [OUT_MAX];
   logic [tll_pkg::ACC_W-1:0]  acc_mem  [OUT_MAX];

   always_ff @(posedge clock) begin
      if (wgt_we) wgt_mem[wgt_waddr] <= wgt_wdata;
      if (rd_ctl.vld) wgt_rdata_ff <= wgt_mem[rd_waddr];
   end

   always_ff @(posedge clock) begin
      if (bias_we) bias_mem[bias_waddr] <= bias_wdata;
      if (rd_ctl.vld) bias_rdata_ff <= bias_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
      if (rd_ctl.vld) acc_rdata_ff <= acc_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) rd_ctl_ff <= '0;
      else       rd_ctl_ff <= rd_ctl;
      rd_idx_ff <= rd_idx;
   end

endmodule

// ===== hw/rtl/tll_mac.sv =====
// two-stage update unit: weight*act >>> 8 (ternary sign select in mode 0), then saturating add
// depends on tll_pkg
module tll_mac #(
   parameter int OUT_MAX   = 16,
   parameter int ACT_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tll_pkg::rd_ctl_type           rd_ctl,
   input  logic [OW-1:0]                 rd_idx,
   input  logic [tll_pkg::WGT_W-1:0]     wgt,
   input  logic [tll_pkg::BIAS_W-1:0]    bias,
   input  logic [tll_pkg::ACC_W-1:0]     acc,
   input  logic [tll_pkg::ACT_W-1:0]     act,
   input  logic                          mode,
   output logic                          acc_we,
   output logic [OW-1:0]                 acc_waddr,
   output logic [tll_pkg::ACC_W-1:0]     acc_wdata,
   output logic                          busy
);

   localparam int OW = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
   localparam int HI = tll_pkg::SUM_W - tll_pkg::ACC_W + 1;

   logic [31:0]                          act_zx;
   logic [ACT_WIDTH-1:0]                 act_low;
   logic signed [31:0]                   act_sx;
   logic signed [tll_pkg::WGT_W-1:0]     wgt_s;
   logic signed [tll_pkg::CONTRIB_W-1:0] prod, c_in, c_ff;
   logic [tll_pkg::ACC_W-1:0]            base_in, base_ff;
   logic                                 vld_ff, vld_in;
   logic [OW-1:0]                        idx_ff;
   logic signed [tll_pkg::SUM_W-1:0]     sum;
   logic [HI-1:0]                        top_bits;

   // activation sign comes from bit ACT_WIDTH-1
   assign act_zx  = 32'(act);
   assign act_low = act_zx[ACT_WIDTH-1:0];
   assign act_sx  = 32'($signed(act_low));
   assign wgt_s   = $signed(wgt);
   assign prod    = tll_pkg::CONTRIB_W'(act_sx) * tll_pkg::CONTRIB_W'(wgt_s);

   always_comb begin
      vld_in  = rd_ctl.vld && rd_ctl.calc;
      base_in = rd_ctl.first ? bias : acc;
      if (mode)
         c_in = prod >>> 8;
      else if (wgt_s == 16'sd1)
         c_in = tll_pkg::CONTRIB_W'(act_sx);
      else if (wgt_s == -16'sd1)
         c_in = -tll_pkg::CONTRIB_W'(act_sx);
      else
         c_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else       vld_ff <= vld_in;
      c_ff    <= c_in;
      base_ff <= base_in;
      idx_ff  <= rd_idx;
   end

   assign sum      = tll_pkg::SUM_W'($signed(base_ff)) + tll_pkg::SUM_W'(c_ff);
   assign top_bits = sum[tll_pkg::SUM_W-1:tll_pkg::ACC_W-1];

   always_comb begin
      if (top_bits != '0 && top_bits != '1)
         acc_wdata = sum[tll_pkg::SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else
         acc_wdata = sum[tll_pkg::ACC_W-1:0];
   end

   assign acc_we    = vld_ff;
   assign acc_waddr = idx_ff;
   assign busy      = vld_ff;

endmodule
